// ----- rtl/lpcnv_pkg.sv -----
// Shared constants, command and status types for the noise-excited LPC synthesiser.
`timescale 1ns / 1ps

package lpcnv_pkg;

    // Filter order and fixed-point format
    localparam int ORDER     = 10;
    localparam int FRAC_BITS = 10;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int TAP_IW    = (ORDER > 1) ? $clog2(ORDER) : 1;

    // Sample and register widths
    localparam int SAMP_W  = 16;
    localparam int PROD_W  = 2 * SAMP_W;
    localparam int DCP_W   = 2 * SAMP_W + 1;
    localparam int IDX_EXT = 6;

    // Noise generator
    localparam logic [SAMP_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [SAMP_W-1:0] LFSR_MASK = 16'hB400;
    localparam logic [SAMP_W-1:0] RND_RANGE = 16'hFFFF;

    // DC blocker factor after reset
    localparam logic [SAMP_W-1:0] DC_RESET = 16'h03CC;

    // Output scaling: |y| / 120 = (|y| >> 3) / 15, the latter by reciprocal
    localparam int DIV_PRESHIFT = 3;
    localparam int MAG_W        = SAMP_W + 1;
    localparam int DIVX_W       = MAG_W - DIV_PRESHIFT;
    localparam int DIVP_W       = 27;
    localparam int DIV_RSHIFT   = 16;
    localparam int DIV_RECIP    = 4370;
    localparam int QMAG_W       = 9;
    localparam int OUT_BIAS     = 128;

    // Input opcodes
    localparam logic [1:0] OP_SET_TAP = 2'd0;
    localparam logic [1:0] OP_FRAME   = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    typedef struct packed {
        logic              wr_tap;
        logic              start_frame;
        logic              noise_step;
        logic              gain_step;
        logic              mac_step;
        logic [TAP_IW-1:0] mac_idx;
        logic              dc_step;
        logic              div_step;
        logic              out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/lpcnv_ctrl.sv -----
// Sequencing state machine for one synthesiser word.
`timescale 1ns / 1ps

module lpcnv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_opcode,
    input  lpcnv_pkg::t_dp_sts i_sts,
    output logic               o_in_stall,
    output lpcnv_pkg::t_dp_cmd o_cmd
);
    import lpcnv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NOISE,
        S_GAIN,
        S_MAC,
        S_DC,
        S_DIV,
        S_OUT
    } t_state;

    t_state            r_state, n_state;
    logic [TAP_IW-1:0] r_cnt, n_cnt;
    logic              accept;
    logic              cnt_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign cnt_last   = (r_cnt == TAP_IW'(ORDER - 1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mac_idx = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        OP_SET_TAP: o_cmd.wr_tap      = 1'b1;
                        OP_FRAME:   o_cmd.start_frame = 1'b1;
                        OP_TICK:    n_state           = S_NOISE;
                        default:    n_state           = S_IDLE;
                    endcase
                end
            end
            S_NOISE: begin
                o_cmd.noise_step = 1'b1;
                n_state          = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain_step = 1'b1;
                n_cnt           = '0;
                n_state         = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_state = S_DC;
                end
            end
            S_DC: begin
                o_cmd.dc_step = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output loaded while the output register still holds a word");

    a_tick_starts_noise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == OP_TICK)) |=> (r_state == S_NOISE))
        else $error("accepted tick did not start the sample sequence");

    a_mac_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_cnt <= TAP_IW'(ORDER - 1)))
        else $error("tap counter ran past the filter order");

    a_mac_leaves_to_dc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MAC) && cnt_last) |=> (r_state == S_DC))
        else $error("accumulation did not hand over to the DC blocker");
`endif

endmodule

// ----- rtl/lpcnv_datapath.sv -----
// Noise generator, shared multiply-accumulate, DC blocker and output scaling.
`timescale 1ns / 1ps

module lpcnv_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpcnv_pkg::t_dp_cmd            i_cmd,
    output lpcnv_pkg::t_dp_sts            o_sts,
    input  logic [3:0]                    i_tap_index,
    input  logic signed [15:0]            i_param_value,
    input  logic                          i_cfg_valid,
    input  logic [15:0]                   i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [7:0]                    o_audio_byte
);
    import lpcnv_pkg::*;

    function automatic logic [SAMP_W-1:0] lfsr_next(input logic [SAMP_W-1:0] v);
        lfsr_next = (v >> 1) ^ (v[0] ? LFSR_MASK : '0);
    endfunction

    logic signed [SAMP_W-1:0] r_taps [ORDER];
    logic signed [SAMP_W-1:0] r_hist [ORDER];
    logic signed [SAMP_W-1:0] r_gain;
    logic signed [SAMP_W-1:0] r_prev_f;
    logic signed [SAMP_W-1:0] r_prev_b;
    logic [SAMP_W-1:0]        r_lfsr;
    logic [SAMP_W-1:0]        r_factor;
    logic signed [SAMP_W-1:0] r_noise;
    logic signed [SAMP_W-1:0] r_acc;
    logic signed [SAMP_W-1:0] r_y;
    logic [QMAG_W-1:0]        r_qmag;
    logic                     r_neg;
    logic                     r_out_valid;
    logic [7:0]               r_out_byte;

    logic [IDX_EXT-1:0]       tap_ext;
    logic                     tap_ok;
    logic [SAMP_W-1:0]        lfsr_1;
    logic [SAMP_W-1:0]        rnd;
    logic signed [SAMP_W-1:0] n_noise;
    logic signed [SAMP_W-1:0] mac_a, mac_b;
    logic signed [PROD_W-1:0] mac_prod;
    logic signed [SAMP_W-1:0] mac_q;
    logic signed [SAMP_W-1:0] n_acc;
    logic signed [DCP_W-1:0]  dc_prod;
    logic signed [SAMP_W-1:0] dc_q;
    logic signed [SAMP_W-1:0] n_y;
    logic signed [MAG_W-1:0]  y_ext;
    logic [MAG_W-1:0]         y_mag;
    logic [DIVP_W-1:0]        div_prod;
    logic [QMAG_W-1:0]        n_qmag;
    logic [QMAG_W:0]          q_signed;
    logic [7:0]               n_out_byte;

    assign tap_ext = IDX_EXT'(i_tap_index);
    assign tap_ok  = (tap_ext < IDX_EXT'(ORDER));

    // First LFSR value, reduced mod 0xFFFF, then mod 2*ONE by masking
    assign lfsr_1  = lfsr_next(r_lfsr);
    assign rnd     = (lfsr_1 == RND_RANGE) ? '0 : lfsr_1;
    assign n_noise = $signed(SAMP_W'(rnd[FRAC_BITS:0]) - SAMP_W'(ONE));

    // Shared multiplier: gain*noise first, then one tap per cycle
    assign mac_a    = i_cmd.gain_step ? r_gain  : r_taps[i_cmd.mac_idx];
    assign mac_b    = i_cmd.gain_step ? r_noise : r_hist[i_cmd.mac_idx];
    assign mac_prod = mac_a * mac_b;
    assign mac_q    = SAMP_W'(mac_prod >>> FRAC_BITS);
    assign n_acc    = i_cmd.gain_step ? mac_q : r_acc + mac_q;

    // DC blocker; the factor is an unsigned magnitude
    assign dc_prod = $signed({1'b0, r_factor}) * r_prev_b;
    assign dc_q    = SAMP_W'(dc_prod >>> FRAC_BITS);
    assign n_y     = r_acc - r_prev_f + dc_q;

    // |y| / 120 by reciprocal multiply, exact over the whole 16-bit range
    assign y_ext    = MAG_W'(r_y);
    assign y_mag    = r_y[SAMP_W-1] ? MAG_W'(-y_ext) : MAG_W'(y_ext);
    assign div_prod = DIVP_W'(y_mag[MAG_W-1:DIV_PRESHIFT]) * DIVP_W'(DIV_RECIP);
    assign n_qmag   = QMAG_W'(div_prod >> DIV_RSHIFT);

    assign q_signed   = r_neg ? (QMAG_W+1)'(-{1'b0, r_qmag}) : {1'b0, r_qmag};
    assign n_out_byte = 8'(q_signed + (QMAG_W+1)'(OUT_BIAS));

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_audio_byte   = r_out_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ORDER; i++) begin
                r_taps[i] <= '0;
                r_hist[i] <= '0;
            end
            r_gain      <= '0;
            r_prev_f    <= '0;
            r_prev_b    <= '0;
            r_lfsr      <= LFSR_SEED;
            r_factor    <= DC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_factor <= i_cfg_data;
            end
            if (i_cmd.wr_tap && tap_ok) begin
                r_taps[tap_ext[TAP_IW-1:0]] <= i_param_value;
            end
            if (i_cmd.start_frame) begin
                r_gain   <= i_param_value;
                r_prev_f <= '0;
                r_prev_b <= '0;
                for (int i = 0; i < ORDER; i++) begin
                    r_hist[i] <= '0;
                end
            end
            if (i_cmd.noise_step) begin
                r_lfsr <= lfsr_next(lfsr_1);
            end
            if (i_cmd.dc_step) begin
                r_prev_f <= r_acc;
                r_prev_b <= n_y;
                for (int i = ORDER - 1; i > 0; i--) begin
                    r_hist[i] <= r_hist[i-1];
                end
                r_hist[0] <= r_acc;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.noise_step) begin
            r_noise <= n_noise;
        end
        if (i_cmd.gain_step || i_cmd.mac_step) begin
            r_acc <= n_acc;
        end
        if (i_cmd.dc_step) begin
            r_y <= n_y;
        end
        if (i_cmd.div_step) begin
            r_qmag <= n_qmag;
            r_neg  <= r_y[SAMP_W-1];
        end
        if (i_cmd.out_load) begin
            r_out_byte <= n_out_byte;
        end
    end

endmodule

// ----- rtl/lpc_noise_excited_voice_synth.sv -----
// Top level of the noise-excited LPC speech synthesiser.
`timescale 1ns / 1ps

// Usage
// The input channel (i_in_valid / o_in_stall) carries one word per command:
// set a filter tap, start a frame with a new gain, or tick one sample. A word
// is taken at a rising edge where i_in_valid is high and o_in_stall is low.
// Tap and frame words complete in the cycle they are taken and give no output.
// A tick word produces one unsigned audio byte on the output channel
// (o_out_valid / i_out_stall) in these steps: the noise generator, the
// gain product, one pass per tap through the shared multiply-accumulate,
// then the DC blocker, the divide-by-120 scaling and the output load. The
// block takes no new word until a tick is through and stalls its input for
// the whole of a tick. A finished byte waits in the output register; while
// the receiver stalls, the next word may still be taken, but a second tick
// holds at its last step until the waiting byte has gone. The DC-blocker
// factor is written through i_cfg_valid / o_cfg_ready, which is always
// ready; the user must write it only while the block is idle, which the
// block does not enforce. Synchronous reset clears taps, history, gain and
// filter state, reseeds the noise generator and restores the default factor.

module lpc_noise_excited_voice_synth (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [3:0]         i_tap_index,
    input  logic signed [15:0] i_param_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_audio_byte,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);
    import lpcnv_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration writes must be issued only while idle; not enforced, all are taken.
    assign o_cfg_ready = 1'b1;

    lpcnv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    lpcnv_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_tap_index   (i_tap_index),
        .i_param_value (i_param_value),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_audio_byte  (o_audio_byte)
    );

endmodule

// ----- dv/lpc_noise_excited_voice_synth_tb.sv -----
// Self-checking testbench for the noise-excited LPC synthesiser with a word-level predictor.
`timescale 1ns / 1ps

module lpc_noise_excited_voice_synth_tb;
    import lpcnv_pkg::*;

    // Opcode 3 has no meaning; the block must swallow it without a byte.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int OUT_DIV = 120;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_WORDS = 420;
    localparam int HOLD_CYCLES = 300;
    localparam int SWEEP_MAX = 64;
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam int MAX_PRINTED = 40;

    // Predicts the audio bytes from the accepted words and checks them in order.
    class whisper_scoreboard;
        logic signed [SAMP_W-1:0] taps [ORDER];
        logic signed [SAMP_W-1:0] history [ORDER];
        logic signed [SAMP_W-1:0] gain;
        logic signed [SAMP_W-1:0] prev_filtered;
        logic signed [SAMP_W-1:0] prev_blocked;
        logic [SAMP_W-1:0] lfsr;
        logic [SAMP_W-1:0] dc_factor;
        logic [7:0] expected_bytes [$];
        int mismatches;
        int words_noted;
        int ticks_noted;
        int bytes_checked;

        function new();
            foreach (taps[k]) begin
                taps[k] = '0;
                history[k] = '0;
            end
            gain = '0;
            prev_filtered = '0;
            prev_blocked = '0;
            lfsr = LFSR_SEED;
            dc_factor = DC_RESET;
            mismatches = 0;
            words_noted = 0;
            ticks_noted = 0;
            bytes_checked = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void set_dc_factor(logic [SAMP_W-1:0] value);
            dc_factor = value;
        endfunction

        // Value the noise register takes at its next step (right shift, mask on carry-out).
        function logic [SAMP_W-1:0] next_draw();
            return (lfsr >> 1) ^ (lfsr[0] ? LFSR_MASK : '0);
        endfunction

        function logic [SAMP_W-1:0] advance_noise();
            lfsr = next_draw();
            return lfsr;
        endfunction

        // Fixed-point product: the exact product over ONE, floored, kept to 16 bits.
        function logic signed [SAMP_W-1:0] fx_mul(longint a, longint b);
            longint p;
            p = a * b;
            return SAMP_W'(p >>> FRAC_BITS);
        endfunction

        function void predict_tick();
            logic signed [SAMP_W-1:0] ny;
            logic signed [SAMP_W-1:0] y;
            int draw;
            int noise;
            int scaled;
            // Only the first of the two steps feeds the noise sample.
            draw = int'(advance_noise()) % int'(RND_RANGE);
            void'(advance_noise());
            noise = draw % (2 * ONE) - ONE;
            ny = fx_mul(gain, noise);
            for (int k = 0; k < ORDER; k++)
                ny = ny + fx_mul(taps[k], history[k]);
            // The DC blocker takes its factor as an unsigned magnitude.
            y = ny - prev_filtered;
            y = y + fx_mul(longint'(dc_factor), prev_blocked);
            prev_filtered = ny;
            prev_blocked = y;
            for (int k = ORDER - 1; k > 0; k--)
                history[k] = history[k - 1];
            history[0] = ny;
            // Division truncates toward zero; the biased sum wraps to a byte.
            scaled = int'(y) / OUT_DIV + OUT_BIAS;
            expected_bytes.push_back(scaled[7:0]);
        endfunction

        function void note_word(logic [1:0] op, logic [3:0] idx, logic signed [SAMP_W-1:0] val);
            words_noted++;
            case (op)
                OP_SET_TAP: begin
                    if (idx < ORDER)
                        taps[idx] = val;
                end
                OP_FRAME: begin
                    // A new frame clears the filter memory but leaves the noise running.
                    gain = val;
                    foreach (history[k])
                        history[k] = '0;
                    prev_filtered = '0;
                    prev_blocked = '0;
                end
                OP_TICK: begin
                    ticks_noted++;
                    predict_tick();
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_byte(logic [7:0] got);
            logic [7:0] want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("audio byte 0x%02h with no tick outstanding", got));
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (got !== want)
                report($sformatf("audio byte 0x%02h, expected 0x%02h", got, want));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_opcode = OP_SET_TAP;
    logic [3:0]         i_tap_index = '0;
    logic signed [15:0] i_param_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [7:0]         o_audio_byte;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [15:0]        i_cfg_data = '0;

    whisper_scoreboard whisper;
    int     tx_gap_pct = 0;
    int     rx_stall_pct = 0;
    int     hold_left = 0;
    int     sweep_ticks = 0;
    longint cycles = 0;

    lpc_noise_excited_voice_synth DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_tap_index   (i_tap_index),
        .i_param_value (i_param_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_audio_byte  (o_audio_byte),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: a counted long hold when one is pending, otherwise random stalls.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            whisper.check_byte(o_audio_byte);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d bytes outstanding.",
                     whisper.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one word, after a random idle gap, and notes it once it is taken.
    task automatic send_word(input logic [1:0] op, input logic [3:0] idx,
                             input logic signed [15:0] val);
        if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_tap_index <= idx;
        i_param_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        whisper.note_word(op, idx, val);
    endtask

    // Waits until every byte has come out and the block has had time to go idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (whisper.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dc_factor(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        whisper.set_dc_factor(value);
    endtask

    task automatic run_directed();
        send_word(OP_TICK, 4'd0, 16'h0000);
        send_word(OP_FRAME, 4'd15, 16'h7FFF);
        repeat (2) send_word(OP_TICK, 4'd0, 16'h0000);
        send_word(OP_SET_TAP, 4'd0, 16'h7FFF);
        send_word(OP_SET_TAP, 4'd9, 16'h8000);
        // Taps beyond the filter order must be ignored.
        send_word(OP_SET_TAP, 4'd10, 16'h1234);
        send_word(OP_SET_TAP, 4'd15, 16'hFFFF);
        send_word(OP_UNUSED, 4'd15, 16'hFFFF);
        repeat (4) send_word(OP_TICK, 4'd15, 16'h7FFF);
        send_word(OP_FRAME, 4'd0, 16'h8000);
        repeat (3) send_word(OP_TICK, 4'd5, 16'h8000);
        send_word(OP_SET_TAP, 4'd5, 16'h0200);
        send_word(OP_FRAME, 4'd7, 16'h0400);
        repeat (3) send_word(OP_TICK, 4'd0, 16'h0000);
        send_word(OP_FRAME, 4'd0, 16'h0000);
        send_word(OP_TICK, 4'd0, 16'h0000);
    endtask

    // One phrase: a few tap writes, a frame start and a run of ticks; now and then
    // a stray word instead. Words the block ignores are not counted.
    task automatic send_phrase(inout int sent);
        int n;
        if ($urandom_range(99) < 8) begin
            case ($urandom_range(2))
                0: send_word(OP_UNUSED, 4'($urandom), 16'($urandom));
                1: send_word(OP_SET_TAP, 4'($urandom_range(15, ORDER)), 16'($urandom));
                default: begin
                    send_word(OP_TICK, 4'($urandom), 16'($urandom));
                    sent++;
                end
            endcase
            return;
        end
        n = $urandom_range(4);
        repeat (n) begin
            // Half the taps are small enough to keep the filter tame.
            send_word(OP_SET_TAP, 4'($urandom_range(ORDER - 1)),
                      16'($urandom_range(1) ? $urandom : $urandom_range(800) - 400));
            sent++;
        end
        if ($urandom_range(9) != 0) begin
            send_word(OP_FRAME, 4'($urandom), 16'($urandom));
            sent++;
        end
        n = $urandom_range(10, 1);
        repeat (n) begin
            send_word(OP_TICK, 4'($urandom), 16'($urandom));
            sent++;
        end
    endtask

    task automatic run_phase(input int gap_pct, input int stall_pct, input bit with_hold);
        int sent;
        sent = 0;
        tx_gap_pct = gap_pct;
        rx_stall_pct <= stall_pct;
        // The hold lets the output back up so that the input must stall too.
        if (with_hold)
            hold_left <= HOLD_CYCLES;
        while (sent < PHASE_WORDS)
            send_phrase(sent);
    endtask

    initial begin
        whisper = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words run with the factor left at its reset value.
        run_directed();
        settle();
        write_dc_factor(16'hFFFF);
        run_phase(0, 0, 1'b0);
        settle();
        write_dc_factor(16'h0000);
        run_phase(70, 0, 1'b0);
        settle();
        write_dc_factor(16'($urandom));
        run_phase(0, 70, 1'b1);
        settle();
        write_dc_factor(16'h0001);
        run_phase(6, 6, 1'b0);
        settle();

        // A short flat-out burst of ticks, ending early if the noise register's
        // first step lands on all ones.
        write_dc_factor(DC_RESET);
        tx_gap_pct = 0;
        rx_stall_pct <= 0;
        send_word(OP_FRAME, 4'd0, 16'($urandom));
        while (whisper.next_draw() != 16'hFFFF && sweep_ticks < SWEEP_MAX) begin
            send_word(OP_TICK, 4'($urandom), 16'($urandom));
            sweep_ticks++;
        end
        send_word(OP_TICK, 4'($urandom), 16'($urandom));
        sweep_ticks++;
        settle();

        $display("Covered %0d words (%0d ticks) and checked %0d bytes, %0d mismatches.",
                 whisper.words_noted, whisper.ticks_noted, whisper.bytes_checked,
                 whisper.mismatches);
        $display("Four idling phases, a long output hold, five DC factors, %0d sweep ticks.",
                 sweep_ticks);
        if (whisper.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
